FILE: hw/rtl/srp_pkg.sv
// Shared types and constants for the shelf rectangle packer.
`default_nettype none

package srp_pkg;

  localparam int DIM_W     = 15;   // rectangle, row and atlas size fields
  localparam int POS_X_W   = 14;
  localparam int ATLAS_H_W = 16;

  localparam logic [DIM_W-1:0] SIZE_RESET = 15'd1024;
  localparam logic [DIM_W-1:0] SIZE_MAX   = 15'd16384;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } in_t;

  typedef struct packed {
    logic [POS_X_W-1:0]   pos_x;
    logic [DIM_W-1:0]     pos_y;
    logic [ATLAS_H_W-1:0] atlas_height;
    logic                 grew;
    logic                 failed;
  } out_t;

  // One shelf of the row table.
  typedef struct packed {
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] used;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic load;    // capture request, clear scan state
    logic first;   // open row 0 with no checks
    logic scan;    // walk the row table
    logic decide;  // one placement attempt at the current height
  } dp_cmd_t;

  typedef struct packed {
    logic rows_empty;
    logic scan_done;
    logic decide_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srp_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/srp_ctrl.sv
// Controller state machine: sequences load, row scan and placement steps.
`default_nettype none

module srp_ctrl import srp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          out_valid,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = stat.rows_empty ? ST_FIRST : ST_SCAN;
        end
      end
      ST_FIRST: begin
        cmd.first     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        // not done means the height was doubled; try again
        if (stat.decide_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/srp_dp.sv
// Datapath: row table, atlas height, scan evaluation and placement choice.
`default_nettype none

module srp_dp import srp_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_HEIGHT = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  input  wire logic             cfg_we,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire in_t              in_item,
  output out_t                  out_item
);

  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HGW = $clog2(MAX_HEIGHT + 1);
  localparam int CHW = (HGW > DIM_W) ? HGW : DIM_W;
  localparam int SW  = ((CHW > 17) ? CHW : 17) + 2;

  localparam logic [SW-1:0] MAX_H     = SW'(MAX_HEIGHT);
  localparam logic [CW-1:0] ROWS_FULL = CW'(MAX_ROWS);

  function automatic logic [DIM_W-1:0] eff_size(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] s;
    s = v;
    if (v == '0) begin
      s = DIM_W'(1);
    end else if (v > SIZE_MAX) begin
      s = SIZE_MAX;
    end
    return s;
  endfunction

  // control state
  logic [DIM_W-1:0] aw_r, aw_nxt;
  logic [CHW-1:0]   cur_r, cur_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  logic             a_hit_r, a_hit_nxt;
  logic             d_hit_r, d_hit_nxt;
  logic             grew_r, grew_nxt;

  // payload
  logic [CHW-1:0]   start_cur_r, start_cur_nxt;
  logic [DIM_W-1:0] w_r, w_nxt;
  logic [DIM_W-1:0] h_r, h_nxt;
  logic [IW-1:0]    ev_idx_r, ev_idx_nxt;
  logic [IW-1:0]    a_idx_r, a_idx_nxt;
  logic [IW-1:0]    d_idx_r, d_idx_nxt;
  row_t             a_row_r, a_row_nxt;
  row_t             d_row_r, d_row_nxt;
  row_t             last_r, last_nxt;    // copy of the last row
  out_t             out_r, out_nxt;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  row_t             ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  row_t             ev_row;
  logic             new_row;

  logic [IW-1:0]    last_idx;
  logic [SW-1:0]    ev_sum, lw_sum, ny, dbl;
  logic             a_test, d_test, b_ok, c_ok, over;

  srp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign ev_row   = row_t'(ram_rdata);
  assign last_idx = IW'(count_r - CW'(1));

  // scan tests: h > floor(3*rh/5) is the same as 5*h > 3*rh
  assign ev_sum = SW'(ev_row.used) + SW'(w_r);
  assign d_test = (h_r < ev_row.h) && (ev_sum < SW'(aw_r));
  assign a_test = d_test &&
                  (((SW'(h_r) << 2) + SW'(h_r)) > ((SW'(ev_row.h) << 1) + SW'(ev_row.h)));

  // grow last row: h < floor(5*lh/3) is the same as 3*h + 3 <= 5*lh
  assign lw_sum = SW'(last_r.used) + SW'(w_r);
  assign b_ok   = (h_r > last_r.h) &&
                  (((SW'(h_r) << 1) + SW'(h_r) + SW'(3)) <=
                   ((SW'(last_r.h) << 2) + SW'(last_r.h))) &&
                  ((SW'(last_r.y) + SW'(h_r)) < SW'(cur_r)) &&
                  (lw_sum < SW'(aw_r));
  assign ny     = SW'(last_r.y) + SW'(last_r.h);
  assign c_ok   = (count_r != ROWS_FULL) && ((ny + SW'(h_r)) < SW'(cur_r));
  assign dbl    = SW'(cur_r) << 1;
  assign over   = dbl > MAX_H;

  always_comb begin
    aw_nxt        = aw_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    ev_valid_nxt  = ev_valid_r;
    a_hit_nxt     = a_hit_r;
    d_hit_nxt     = d_hit_r;
    grew_nxt      = grew_r;
    start_cur_nxt = start_cur_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    ev_idx_nxt    = ev_idx_r;
    a_idx_nxt     = a_idx_r;
    d_idx_nxt     = d_idx_r;
    a_row_nxt     = a_row_r;
    d_row_nxt     = d_row_r;
    last_nxt      = last_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    new_row       = 1'b0;
    stat          = '0;

    stat.rows_empty = (count_r == '0);
    stat.scan_done  = ev_valid_r && (ev_idx_r == last_idx);

    if (cfg_we) begin
      aw_nxt    = eff_size(cfg_data);
      cur_nxt   = CHW'(eff_size(cfg_data));
      count_nxt = '0;
    end

    if (cmd.load) begin
      w_nxt         = in_item.rect_width;
      h_nxt         = in_item.rect_height;
      start_cur_nxt = cur_r;
      grew_nxt      = 1'b0;
      rd_cnt_nxt    = '0;
      ev_valid_nxt  = 1'b0;
      a_hit_nxt     = 1'b0;
      d_hit_nxt     = 1'b0;
    end

    if (cmd.first) begin
      ram_we         = 1'b1;
      ram_waddr      = '0;
      ram_wdata      = '{y: '0, h: h_r, used: w_r};
      new_row        = 1'b1;
      count_nxt      = CW'(1);
      out_nxt        = '0;
      out_nxt.atlas_height = ATLAS_H_W'(cur_r);
    end

    if (cmd.scan) begin
      // read one row a beat, evaluate the row read the beat before
      ev_valid_nxt = (rd_cnt_r < count_r);
      ev_idx_nxt   = rd_cnt_r[IW-1:0];
      if (rd_cnt_r < count_r) begin
        rd_cnt_nxt = rd_cnt_r + CW'(1);
      end
      if (ev_valid_r) begin
        if (a_test && !a_hit_r) begin
          a_hit_nxt = 1'b1;
          a_idx_nxt = ev_idx_r;
          a_row_nxt = ev_row;
        end
        if (d_test && !d_hit_r) begin
          d_hit_nxt = 1'b1;
          d_idx_nxt = ev_idx_r;
          d_row_nxt = ev_row;
        end
      end
    end

    if (cmd.decide) begin
      stat.decide_done     = 1'b1;
      out_nxt              = '0;
      out_nxt.atlas_height = ATLAS_H_W'(cur_r);
      out_nxt.grew         = grew_r;
      if (a_hit_r) begin
        ram_we        = 1'b1;
        ram_waddr     = a_idx_r;
        ram_wdata     = '{y: a_row_r.y, h: a_row_r.h,
                          used: DIM_W'(SW'(a_row_r.used) + SW'(w_r))};
        out_nxt.pos_x = POS_X_W'(a_row_r.used);
        out_nxt.pos_y = a_row_r.y;
      end else if (b_ok) begin
        ram_we        = 1'b1;
        ram_waddr     = last_idx;
        ram_wdata     = '{y: last_r.y, h: h_r, used: DIM_W'(lw_sum)};
        out_nxt.pos_x = POS_X_W'(last_r.used);
        out_nxt.pos_y = last_r.y;
      end else if (c_ok) begin
        ram_we        = 1'b1;
        ram_waddr     = count_r[IW-1:0];
        ram_wdata     = '{y: DIM_W'(ny), h: h_r, used: w_r};
        new_row       = 1'b1;
        count_nxt     = count_r + CW'(1);
        out_nxt.pos_y = DIM_W'(ny);
      end else if (d_hit_r) begin
        ram_we        = 1'b1;
        ram_waddr     = d_idx_r;
        ram_wdata     = '{y: d_row_r.y, h: d_row_r.h,
                          used: DIM_W'(SW'(d_row_r.used) + SW'(w_r))};
        out_nxt.pos_x = POS_X_W'(d_row_r.used);
        out_nxt.pos_y = d_row_r.y;
      end else if (over) begin
        // give up and undo any doubling done for this request
        cur_nxt              = start_cur_r;
        out_nxt.atlas_height = ATLAS_H_W'(start_cur_r);
        out_nxt.grew         = 1'b0;
        out_nxt.failed       = 1'b1;
      end else begin
        // later attempts need no rescan: the any-row test ignores height
        stat.decide_done = 1'b0;
        cur_nxt          = CHW'(dbl);
        grew_nxt         = 1'b1;
        a_hit_nxt        = 1'b0;
        d_hit_nxt        = 1'b0;
      end
    end

    if (ram_we && (new_row || (ram_waddr == last_idx))) begin
      last_nxt = ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r       <= SIZE_RESET;
      cur_r      <= CHW'(SIZE_RESET);
      count_r    <= '0;
      rd_cnt_r   <= '0;
      ev_valid_r <= 1'b0;
      a_hit_r    <= 1'b0;
      d_hit_r    <= 1'b0;
      grew_r     <= 1'b0;
    end else begin
      aw_r       <= aw_nxt;
      cur_r      <= cur_nxt;
      count_r    <= count_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      ev_valid_r <= ev_valid_nxt;
      a_hit_r    <= a_hit_nxt;
      d_hit_r    <= d_hit_nxt;
      grew_r     <= grew_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_cur_r <= start_cur_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    ev_idx_r    <= ev_idx_nxt;
    a_idx_r     <= a_idx_nxt;
    d_idx_r     <= d_idx_nxt;
    a_row_r     <= a_row_nxt;
    d_row_r     <= d_row_nxt;
    last_r      <= last_nxt;
    out_r       <= out_nxt;
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

FILE: hw/rtl/shelf_rectangle_packer.sv
// Top level of the shelf rectangle packer.
//
// One request at a time: a request is taken when start is high and busy is
// low, and its result shows on out_item for a single cycle with out_valid
// high, in the cycle busy drops; the receiver must take it then, it cannot
// stall. The first request after reset or a configuration write skips the
// row scan. Any other request walks the row table, which sits in a
// single-read-port RAM, one row a cycle, once per request, and then tries
// a placement, once more after each height doubling.
// A write on the cfg channel sets the atlas size and starts an empty atlas;
// cfg_ready is high only while the block is idle and start is low.
`default_nettype none

module shelf_rectangle_packer import srp_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_HEIGHT = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_t              in_item,
  output logic                  out_valid,
  output out_t                  out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [DIM_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // a request beat wins over a size write in the same cycle
  assign cfg_ready = !busy && !start;

  srp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  srp_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
